// ===== hw/rtl/dqf_pkg.sv =====
// Shared types, widths and register indexes for the detector quality flagger.
package dqf_pkg;

   // Default sizing of the sample buffer and the quality words
   localparam int DQF_MAX_SAMPLES  = 64;
   localparam int DQF_QUALITY_BITS = 16;

   // Fixed field widths
   localparam int QUAL_W      = 16;
   localparam int DATA_W      = 64;
   localparam int THRESH_W    = 7;
   localparam int BAD_COUNT_W = 7;
   localparam int CSR_INDEX_W = 3;
   localparam int LOW_W       = 32;

   // Register reset values
   localparam logic [THRESH_W-1:0] BAD_THRESHOLD_RESET    = 7'd64;
   localparam logic [DATA_W-1:0]   BAD_VALUE_RESET        = 64'hFFEF_FFFF_FFFF_FFFF;
   localparam logic [QUAL_W-1:0]   BAD_DATA_BIT_RESET     = 16'h0001;
   localparam logic [QUAL_W-1:0]   BAD_DETECTOR_BIT_RESET = 16'h0002;

   // Highest value the bad sample counter holds before it saturates
   localparam logic [BAD_COUNT_W-1:0] BAD_COUNT_MAX = '1;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYNC_ENABLE      = 3'd0,
      CSR_FRAC_ENABLE      = 3'd1,
      CSR_BAD_THRESHOLD    = 3'd2,
      CSR_EXTRA_QUALITY    = 3'd3,
      CSR_INTEGER_DATA     = 3'd4,
      CSR_BAD_VALUE        = 3'd5,
      CSR_BAD_DATA_BIT     = 3'd6,
      CSR_BAD_DETECTOR_BIT = 3'd7
   } csr_index_type;

   // Control sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   // One input sample
   typedef struct packed {
      logic [QUAL_W-1:0] quality_in;
      logic [DATA_W-1:0] data_word;
      logic              detector_masked;
      logic              last_sample;
   } req_type;

   // One emitted sample
   typedef struct packed {
      logic [QUAL_W-1:0] quality_out;
      logic [DATA_W-1:0] data_out;
      logic              overflowed;
      logic              last_out;
   } rsp_type;

endpackage

// ===== hw/rtl/dqf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module dqf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data, hold it otherwise
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/detector_quality_flagger.sv =====
// Top level: buffers one detector's samples, syncs and counts bad ones, flags and emits them.
// Intake: one sample per cycle while busy is low; each sample is written once to the buffer RAM,
//   or dropped with overflow set when the buffer is full. Emit: after the last sample, the
//   buffered samples come out on consecutive cycles, through the state register and then the
//   RAM's registered read data; busy is high while they are read, so no new sample is taken.
// The receiver cannot stall: each result is strobed by rsp_valid for exactly one cycle.
// Reset (synchronous) clears counts, flags and sequencer and restores register defaults;
//   the buffer RAM is not cleared, since every entry is written before it is read.
module detector_quality_flagger
   import dqf_pkg::*;
#(
   parameter int MAX_SAMPLES  = DQF_MAX_SAMPLES,
   parameter int QUALITY_BITS = DQF_QUALITY_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   // sample input
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_item,
   // result output
   output logic                   rsp_valid,
   output rsp_type                rsp_item,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_data
);

   // Stored quality width: inputs are 16 bits, then cut to QUALITY_BITS
   localparam int QW     = (QUALITY_BITS < QUAL_W) ? QUALITY_BITS : QUAL_W;
   localparam int AW     = $clog2(MAX_SAMPLES);
   localparam int CW     = $clog2(MAX_SAMPLES + 1);
   localparam int RAM_W  = QW + DATA_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_SAMPLES);

   // Configuration registers
   logic                sync_enable_ff;
   logic                frac_enable_ff;
   logic [THRESH_W-1:0] bad_threshold_ff;
   logic [QUAL_W-1:0]   extra_quality_ff;
   logic                integer_data_ff;
   logic [DATA_W-1:0]   bad_value_ff;
   logic [QUAL_W-1:0]   bad_data_bit_ff;
   logic [QUAL_W-1:0]   bad_detector_bit_ff;

   // Detector state and sequencer
   state_type              state_ff, state_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic [BAD_COUNT_W-1:0] bad_count_ff, bad_count_in;
   logic                   masked_ff, masked_in;
   logic                   overflow_ff, overflow_in;
   logic                   flag_ff, flag_in;
   logic                   ovf_out_ff, ovf_out_in;
   logic [CW-1:0]          emit_count_ff, emit_count_in;
   logic [AW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic                   rd_last_ff, rd_last_in;

   // Intake conditioning
   logic              accept;
   logic [QW-1:0]     q_cut;
   logic [QW-1:0]     bdb;
   logic [QW-1:0]     q_sync;
   logic [DATA_W-1:0] d_sync;
   logic [DATA_W-1:0] sentinel;
   logic              sentinel_hit;
   logic              sample_bad;
   logic              masked_next;
   logic              overflow_next;
   logic [CW-1:0]           fill_next;
   logic [BAD_COUNT_W-1:0]  bad_next;

   // RAM ports
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [RAM_W-1:0] wr_data;
   logic             rd_en;
   logic [RAM_W-1:0] rd_data;
   logic [QW-1:0]    flag_bits;
   logic [QW-1:0]    q_emit;
   logic             read_last;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_enable_ff      <= 1'b0;
         frac_enable_ff      <= 1'b0;
         bad_threshold_ff    <= BAD_THRESHOLD_RESET;
         extra_quality_ff    <= '0;
         integer_data_ff     <= 1'b0;
         bad_value_ff        <= BAD_VALUE_RESET;
         bad_data_bit_ff     <= BAD_DATA_BIT_RESET;
         bad_detector_bit_ff <= BAD_DETECTOR_BIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SYNC_ENABLE:      sync_enable_ff      <= csr_data[0];
            CSR_FRAC_ENABLE:      frac_enable_ff      <= csr_data[0];
            CSR_BAD_THRESHOLD:    bad_threshold_ff    <= csr_data[THRESH_W-1:0];
            CSR_EXTRA_QUALITY:    extra_quality_ff    <= csr_data[QUAL_W-1:0];
            CSR_INTEGER_DATA:     integer_data_ff     <= csr_data[0];
            CSR_BAD_VALUE:        bad_value_ff        <= csr_data;
            CSR_BAD_DATA_BIT:     bad_data_bit_ff     <= csr_data[QUAL_W-1:0];
            CSR_BAD_DETECTOR_BIT: bad_detector_bit_ff <= csr_data[QUAL_W-1:0];
            default: ;
         endcase
      end
   end

   // Sync sentinel data and bad-data quality bit, classify the sample
   always_comb begin
      q_cut    = req_item.quality_in[QW-1:0];
      bdb      = bad_data_bit_ff[QW-1:0];
      sentinel = integer_data_ff ? {{(DATA_W-LOW_W){1'b0}}, bad_value_ff[LOW_W-1:0]}
                                 : bad_value_ff;
      sentinel_hit = integer_data_ff
                   ? (req_item.data_word[LOW_W-1:0] == bad_value_ff[LOW_W-1:0])
                   : (req_item.data_word == bad_value_ff);
      q_sync = q_cut;
      d_sync = req_item.data_word;
      if (sync_enable_ff) begin
         if (sentinel_hit) begin
            q_sync = q_cut | bdb;
         end else if ((q_cut & bdb) != '0) begin
            d_sync = sentinel;
         end
         sample_bad = ((q_sync & bdb) != '0);
      end else begin
         sample_bad = ((q_cut & bdb) != '0) || sentinel_hit;
      end
   end

   // Next state: take samples, then read the buffer back out
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      bad_count_in  = bad_count_ff;
      masked_in     = masked_ff;
      overflow_in   = overflow_ff;
      flag_in       = flag_ff;
      ovf_out_in    = ovf_out_ff;
      emit_count_in = emit_count_ff;
      rd_ptr_in     = rd_ptr_ff;
      rd_valid_in   = 1'b0;
      rd_last_in    = rd_last_ff;
      wr_en         = 1'b0;
      wr_addr       = fill_ff[AW-1:0];
      wr_data       = {q_sync, d_sync};
      rd_en         = 1'b0;
      read_last     = ((CW'(rd_ptr_ff) + CW'(1)) == emit_count_ff);
      masked_next   = masked_ff || req_item.detector_masked;
      overflow_next = overflow_ff;
      fill_next     = fill_ff;
      bad_next      = bad_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // store the sample, or drop it when the buffer is full
               if (fill_ff != FULL_COUNT) begin
                  wr_en     = 1'b1;
                  fill_next = fill_ff + CW'(1);
                  if (sample_bad && (bad_count_ff != BAD_COUNT_MAX)) begin
                     bad_next = bad_count_ff + BAD_COUNT_W'(1);
                  end
               end else begin
                  overflow_next = 1'b1;
               end
               masked_in    = masked_next;
               overflow_in  = overflow_next;
               fill_in      = fill_next;
               bad_count_in = bad_next;
               // on the last sample, decide the flag and start emitting
               if (req_item.last_sample) begin
                  flag_in       = masked_next ||
                                  (frac_enable_ff && (bad_next > bad_threshold_ff));
                  ovf_out_in    = overflow_next;
                  emit_count_in = fill_next;
                  rd_ptr_in     = '0;
                  fill_in       = '0;
                  bad_count_in  = '0;
                  masked_in     = 1'b0;
                  overflow_in   = 1'b0;
                  state_in      = ST_READ;
               end
            end
         end
         ST_READ: begin
            // issue one read per cycle
            rd_en       = 1'b1;
            rd_valid_in = 1'b1;
            rd_last_in  = read_last;
            rd_ptr_in   = rd_ptr_ff + AW'(1);
            if (read_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         bad_count_ff  <= '0;
         masked_ff     <= 1'b0;
         overflow_ff   <= 1'b0;
         flag_ff       <= 1'b0;
         ovf_out_ff    <= 1'b0;
         emit_count_ff <= '0;
         rd_ptr_ff     <= '0;
         rd_valid_ff   <= 1'b0;
         rd_last_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         bad_count_ff  <= bad_count_in;
         masked_ff     <= masked_in;
         overflow_ff   <= overflow_in;
         flag_ff       <= flag_in;
         ovf_out_ff    <= ovf_out_in;
         emit_count_ff <= emit_count_in;
         rd_ptr_ff     <= rd_ptr_in;
         rd_valid_ff   <= rd_valid_in;
         rd_last_ff    <= rd_last_in;
      end
   end

   // Sample buffer: quality word and data word side by side
   dqf_ram #(
      .WIDTH(RAM_W),
      .DEPTH(MAX_SAMPLES)
   ) u_buffer (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_ptr_ff),
      .rd_data(rd_data)
   );

   // OR in the whole-detector bits on a flagged detector, drive the result
   assign flag_bits = flag_ff ? (bad_detector_bit_ff[QW-1:0] | extra_quality_ff[QW-1:0])
                              : '0;
   assign q_emit    = rd_data[RAM_W-1:DATA_W] | flag_bits;

   assign rsp_valid            = rd_valid_ff;
   assign rsp_item.quality_out = QUAL_W'(q_emit);
   assign rsp_item.data_out    = rd_data[DATA_W-1:0];
   assign rsp_item.overflowed  = ovf_out_ff;
   assign rsp_item.last_out    = rd_last_ff;

   // A result only follows a read issued in the cycle before
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_READ))
      else $error("result strobe without a preceding buffer read");

   // The final result ends the burst
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last_out) |=> !rsp_valid)
      else $error("result strobe after the final result");

   // A last sample taken starts emission
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.last_sample) |=> (state_ff == ST_READ))
      else $error("last sample did not start emission");

   // Fill count never passes the buffer depth
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_COUNT)
      else $error("fill count beyond buffer depth");

   // Emission always has at least one sample to send
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (emit_count_ff != '0))
      else $error("emission started on an empty buffer");

endmodule
